// ===== design/pp_pkg.sv =====
// Shared types and constants for the perspective projection block.
package pp_pkg;

  localparam int CoordWidth = 32;
  localparam int SizeWidth  = 14;
  localparam int CfgIdxWidth = 4;
  localparam int CfgDataWidth = 64;
  localparam int MatRegs = 6;

  localparam logic [CfgIdxWidth-1:0] RegRow0Cols01 = 4'd0;
  localparam logic [CfgIdxWidth-1:0] RegRow0Cols23 = 4'd1;
  localparam logic [CfgIdxWidth-1:0] RegRow1Cols01 = 4'd2;
  localparam logic [CfgIdxWidth-1:0] RegRow1Cols23 = 4'd3;
  localparam logic [CfgIdxWidth-1:0] RegRow3Cols01 = 4'd4;
  localparam logic [CfgIdxWidth-1:0] RegRow3Cols23 = 4'd5;
  localparam logic [CfgIdxWidth-1:0] RegScreenWidth = 4'd6;
  localparam logic [CfgIdxWidth-1:0] RegScreenHeight = 4'd7;

  localparam logic [SizeWidth-1:0] WidthReset  = 14'd1920;
  localparam logic [SizeWidth-1:0] HeightReset = 14'd1080;

  typedef enum logic [1:0] {
    STATUS_BEHIND    = 2'd0,
    STATUS_OFFSCREEN = 2'd1,
    STATUS_ONSCREEN  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] pos_x;
    logic signed [CoordWidth-1:0] pos_y;
    logic signed [CoordWidth-1:0] pos_z;
  } point_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] screen_x;
    logic signed [CoordWidth-1:0] screen_y;
    status_t                      status;
  } result_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_sts_t;

endpackage

// ===== design/pp_front.sv =====
// Front end: matrix row terms, behind-camera test, divider operands.
module pp_front import pp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   accept,
  input  point_t                                 point,
  input  logic [MatRegs-1:0][CfgDataWidth-1:0]   mat,
  output logic                                   push,
  output logic [3*(67-FRAC_BITS)+(66-FRAC_BITS):0] entry
);

  localparam int TermW = 64 - FRAC_BITS;
  localparam int SumW  = 66 - FRAC_BITS;
  localparam int AW    = 67 - FRAC_BITS;
  localparam int DW    = 66 - FRAC_BITS;
  localparam logic signed [SumW-1:0] WMinRaw =
    SumW'(((64'sd1 <<< FRAC_BITS) + 64'sd500) / 64'sd1000);
  localparam logic signed [SumW-1:0] WMin = (WMinRaw < 1) ? SumW'(1) : WMinRaw;

  logic                  s1_valid;
  logic signed [63:0]    prod [3][3];
  logic signed [31:0]    offs [3];
  logic signed [SumW-1:0] row_sum [3];
  logic signed [AW-1:0]  num_x, num_y;
  logic                  behind;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    for (int r = 0; r < 3; r++) begin
      prod[r][0] <= $signed(mat[2*r][31:0])   * point.pos_x;
      prod[r][1] <= $signed(mat[2*r][63:32])  * point.pos_y;
      prod[r][2] <= $signed(mat[2*r+1][31:0]) * point.pos_z;
      offs[r]    <= $signed(mat[2*r+1][63:32]);
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = SumW'(TermW'(prod[r][0] >>> FRAC_BITS))
                 + SumW'(TermW'(prod[r][1] >>> FRAC_BITS))
                 + SumW'(TermW'(prod[r][2] >>> FRAC_BITS))
                 + SumW'(offs[r]);
    end
    behind = row_sum[2] < WMin;
    num_x  = AW'(row_sum[2]) + AW'(row_sum[0]);
    num_y  = AW'(row_sum[2]) - AW'(row_sum[1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= s1_valid;
    end
    entry <= {behind, num_x, num_y, DW'({row_sum[2], 1'b0}), {AW{1'b0}}};
  end

endmodule

// ===== design/pp_queue.sv =====
// Short request queue between the front end and the divider back end.
module pp_queue import pp_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  queue_ctl_t       ctl,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata,
  output queue_sts_t       sts
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push, do_pop;

  assign sts.empty = (count == '0);
  assign sts.full  = (count == CW'(DEPTH));
  assign do_push   = ctl.push && !sts.full;
  assign do_pop    = ctl.pop && !sts.empty;
  assign rdata     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== design/pp_back.sv =====
// Back end: viewport scaling, pipelined division, saturation and screen test.
module pp_back import pp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   take,
  input  logic [3*(67-FRAC_BITS)+(66-FRAC_BITS):0] entry,
  input  logic [SizeWidth-1:0]                   width,
  input  logic [SizeWidth-1:0]                   height,
  output logic                                   done,
  output result_t                                result
);

  localparam int AW = 67 - FRAC_BITS;
  localparam int DW = 66 - FRAC_BITS;
  localparam int PW = AW + SizeWidth;
  localparam int NW = PW + FRAC_BITS;
  localparam int QB = 33;
  localparam int HW = NW - QB;
  localparam int CW = ((HW > DW) ? HW : DW) + 1;
  localparam int BW = (((14 + FRAC_BITS) > 32) ? (14 + FRAC_BITS) : 32) + 1;

  logic                 e_behind;
  logic signed [AW-1:0] e_nx, e_ny;
  logic [DW-1:0]        e_den;
  logic [AW-1:0]        mag_x, mag_y;

  assign e_behind = entry[3*AW+DW];
  assign e_nx     = entry[3*AW+DW-1 -: AW];
  assign e_ny     = entry[2*AW+DW-1 -: AW];
  assign e_den    = entry[AW+DW-1 -: DW];
  assign mag_x    = e_nx[AW-1] ? AW'(-e_nx) : AW'(e_nx);
  assign mag_y    = e_ny[AW-1] ? AW'(-e_ny) : AW'(e_ny);

  logic          b0_valid, b0_behind;
  logic [1:0]    b0_neg;
  logic [PW-1:0] b0_prod [2];
  logic [DW-1:0] b0_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_valid <= 1'b0;
    end else begin
      b0_valid <= take;
    end
    b0_behind  <= e_behind;
    b0_neg     <= {e_ny[AW-1], e_nx[AW-1]};
    b0_prod[0] <= PW'(mag_x) * PW'(width);
    b0_prod[1] <= PW'(mag_y) * PW'(height);
    b0_den     <= e_den;
  end

  logic          st_valid  [QB+1];
  logic          st_behind [QB+1];
  logic [1:0]    st_neg    [QB+1];
  logic [1:0]    st_ovf    [QB+1];
  logic [DW-1:0] st_den    [QB+1];
  logic [DW-1:0] st_rem    [QB+1][2];
  logic [QB-1:0] st_lo     [QB+1][2];
  logic [QB-1:0] st_q      [QB+1][2];

  always_ff @(posedge clk) begin
    logic [NW-1:0] n;
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else begin
      st_valid[0] <= b0_valid;
    end
    st_behind[0] <= b0_behind;
    st_neg[0]    <= b0_neg;
    st_den[0]    <= b0_den;
    for (int l = 0; l < 2; l++) begin
      n = {b0_prod[l], {FRAC_BITS{1'b0}}};
      st_ovf[0][l] <= CW'(n[NW-1:QB]) >= CW'(b0_den);
      st_rem[0][l] <= DW'(n[NW-1:QB]);
      st_lo[0][l]  <= n[QB-1:0];
      st_q[0][l]   <= '0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [DW:0] trial [2];
    logic        ge    [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        trial[l] = {st_rem[k][l], st_lo[k][l][QB-1-k]};
        ge[l]    = trial[l] >= {1'b0, st_den[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k+1] <= 1'b0;
      end else begin
        st_valid[k+1] <= st_valid[k];
      end
      st_behind[k+1] <= st_behind[k];
      st_neg[k+1]    <= st_neg[k];
      st_ovf[k+1]    <= st_ovf[k];
      st_den[k+1]    <= st_den[k];
      for (int l = 0; l < 2; l++) begin
        st_rem[k+1][l] <= ge[l] ? DW'(trial[l] - {1'b0, st_den[k]}) : DW'(trial[l]);
        st_lo[k+1][l]  <= st_lo[k][l];
        st_q[k+1][l]   <= {st_q[k][l][QB-2:0], ge[l]};
      end
    end
  end

  logic signed [CoordWidth-1:0] sat [2];
  logic                         big [2];
  logic                         in_x, in_y;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      big[l] = st_ovf[QB][l] || (st_q[QB][l][QB-1:31] != '0);
      if (st_neg[QB][l]) begin
        sat[l] = big[l] ? 32'sh8000_0000 : -$signed(st_q[QB][l][31:0]);
      end else begin
        sat[l] = big[l] ? 32'sh7fff_ffff : $signed(st_q[QB][l][31:0]);
      end
    end
    in_x = !sat[0][31] && (BW'(sat[0][30:0]) <= (BW'(width) << FRAC_BITS));
    in_y = !sat[1][31] && (BW'(sat[1][30:0]) <= (BW'(height) << FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= st_valid[QB];
    end
    if (st_behind[QB]) begin
      result.screen_x <= '0;
      result.screen_y <= '0;
      result.status   <= STATUS_BEHIND;
    end else begin
      result.screen_x <= sat[0];
      result.screen_y <= sat[1];
      result.status   <= (in_x && in_y) ? STATUS_ONSCREEN : STATUS_OFFSCREEN;
    end
  end

endmodule

// ===== design/perspective_projection.sv =====
// Perspective projection top level: registers, front end, queue, back end.
// The done strobe is registered in the back end, behind the front end, queue and divider stages.
// Throughput: one point per cycle; the 33-stage restoring divider sets the depth.
// busy rises only if the request queue fills, which the back end never lets happen.
// Synchronous reset clears all valid flags and the queue; matrix resets to zero,
// viewport to 1920 by 1080. Results cannot be stalled by the receiver.
module perspective_projection import pp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  point_t                  point,
  output logic                    done,
  output result_t                 result,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data
);

  localparam int EW = 3 * (67 - FRAC_BITS) + (66 - FRAC_BITS) + 1;

  logic [MatRegs-1:0][CfgDataWidth-1:0] mat;
  logic [SizeWidth-1:0] width, height;
  logic                 push;
  logic [EW-1:0]        f_entry, q_entry;
  queue_ctl_t           q_ctl;
  queue_sts_t           q_sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mat    <= '0;
      width  <= WidthReset;
      height <= HeightReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegRow0Cols01:   mat[0] <= cfg_data;
        RegRow0Cols23:   mat[1] <= cfg_data;
        RegRow1Cols01:   mat[2] <= cfg_data;
        RegRow1Cols23:   mat[3] <= cfg_data;
        RegRow3Cols01:   mat[4] <= cfg_data;
        RegRow3Cols23:   mat[5] <= cfg_data;
        RegScreenWidth:  width  <= cfg_data[SizeWidth-1:0];
        RegScreenHeight: height <= cfg_data[SizeWidth-1:0];
        default: ;
      endcase
    end
  end

  assign busy       = q_sts.full;
  assign q_ctl.push = push;
  assign q_ctl.pop  = !q_sts.empty;

  pp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (start && !busy),
    .point  (point),
    .mat    (mat),
    .push   (push),
    .entry  (f_entry)
  );

  pp_queue #(.WIDTH(EW), .DEPTH(2)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .ctl   (q_ctl),
    .wdata (f_entry),
    .rdata (q_entry),
    .sts   (q_sts)
  );

  pp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk    (clk),
    .rst    (rst),
    .take   (!q_sts.empty),
    .entry  (q_entry),
    .width  (width),
    .height (height),
    .done   (done),
    .result (result)
  );

endmodule

// ===== tb/perspective_projection_tb.sv =====
// Self-checking testbench for the perspective projection block.
module perspective_projection_tb;
  import pp_pkg::*;

  localparam int FracBits = 16;
  localparam longint WMin = ((longint'(1) << FracBits) + 500) / 1000;
  localparam int Latency = 38;
  localparam longint CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  point_t point = '0;
  logic done;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  logic [63:0] mat_q[6];
  logic [SizeWidth-1:0] width_q;
  logic [SizeWidth-1:0] height_q;
  result_t projected_q[$];
  int mismatches = 0;
  longint cycles = 0;
  bit gaps_on = 1'b1;

  perspective_projection dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .point(point),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL perspective_projection");
      $finish;
    end
  end

  function automatic longint floor_q(longint v);
    return v >>> FracBits;
  endfunction

  function automatic longint row_term(int r, longint x, longint y, longint z);
    longint c0, c1, c2, c3;
    c0 = longint'($signed(mat_q[2*r][31:0]));
    c1 = longint'($signed(mat_q[2*r][63:32]));
    c2 = longint'($signed(mat_q[2*r+1][31:0]));
    c3 = longint'($signed(mat_q[2*r+1][63:32]));
    return floor_q(c0 * x) + floor_q(c1 * y) + floor_q(c2 * z) + c3;
  endfunction

  function automatic logic signed [31:0] viewport_div(longint num, longint sz, longint den);
    logic [127:0] a;
    logic [127:0] q;
    bit neg;
    neg = num < 0;
    a = neg ? 128'(-num) : 128'(num);
    q = ((a * 128'(sz)) << FracBits) / 128'(den);
    if (neg) return (q >= 128'h8000_0000) ? 32'sh8000_0000 : -$signed(q[31:0]);
    return (q > 128'h7fff_ffff) ? 32'sh7fff_ffff : q[31:0];
  endfunction

  function automatic result_t project_point(point_t p);
    result_t r;
    longint x, y, z, tx, ty, tw, sx, sy;
    x = p.pos_x;
    y = p.pos_y;
    z = p.pos_z;
    tx = row_term(0, x, y, z);
    ty = row_term(1, x, y, z);
    tw = row_term(2, x, y, z);
    r = '0;
    r.status = STATUS_BEHIND;
    if (tw < WMin) return r;
    r.screen_x = viewport_div(tw + tx, width_q, 2 * tw);
    r.screen_y = viewport_div(tw - ty, height_q, 2 * tw);
    sx = r.screen_x;
    sy = r.screen_y;
    r.status = (sx >= 0 && sx <= (longint'(width_q) << FracBits) && sy >= 0 &&
                sy <= (longint'(height_q) << FracBits)) ? STATUS_ONSCREEN : STATUS_OFFSCREEN;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && done) begin
      if (projected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        exp_r = projected_q.pop_front();
        if (result.screen_x !== exp_r.screen_x || result.screen_y !== exp_r.screen_y ||
            result.status !== exp_r.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%h y=%h s=%0d, got x=%h y=%h s=%0d",
                     exp_r.screen_x, exp_r.screen_y, exp_r.status,
                     result.screen_x, result.screen_y, result.status);
        end
      end
    end
  end

  task automatic idle_burst();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  task automatic send_point(point_t p);
    idle_burst();
    start <= 1'b1;
    point <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    projected_q.push_back(project_point(p));
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (projected_q.size() != 0) @(negedge clk);
    repeat (Latency + 4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < MatRegs) mat_q[idx] = val;
    else if (idx == RegScreenWidth) width_q = val[SizeWidth-1:0];
    else if (idx == RegScreenHeight) height_q = val[SizeWidth-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    p.pos_x = rand_q();
    p.pos_y = rand_q();
    p.pos_z = rand_q();
    return p;
  endfunction

  task automatic load_camera(logic [31:0] sc, logic [31:0] wz, logic [31:0] wc);
    write_reg(RegRow0Cols01, {32'h0, sc});
    write_reg(RegRow0Cols23, {32'h0, 32'h0});
    write_reg(RegRow1Cols01, {sc, 32'h0});
    write_reg(RegRow1Cols23, {32'h0, 32'h0});
    write_reg(RegRow3Cols01, {32'h0, 32'h0});
    write_reg(RegRow3Cols23, {wc, wz});
  endtask

  task automatic test_reset_values();
    point_t p;
    p = '0;
    send_point(p);
    p.pos_z = 32'h7fff_ffff;
    send_point(p);
    drain();
  endtask

  task automatic test_directed();
    point_t p;
    load_camera(32'h0001_0000, 32'h0001_0000, 32'h0);
    p = '{32'h0, 32'h0, 32'h0001_0000};
    send_point(p);
    p = '{32'h0001_0000, 32'hffff_0000, 32'h0001_0000};
    send_point(p);
    p = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
    send_point(p);
    p = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0041};
    send_point(p);
    p = '{32'h0, 32'h0, 32'h0000_0042};
    send_point(p);
    p = '{32'h0, 32'h0, 32'h0000_0040};
    send_point(p);
    p = '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff};
    send_point(p);
    p = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
    send_point(p);
    drain();
    write_reg(RegScreenWidth, 64'd8192);
    write_reg(RegScreenHeight, 64'd1);
    p = '{32'h0001_0000, 32'hffff_0000, 32'h0001_0000};
    send_point(p);
    p = '{32'h0000_8000, 32'h0, 32'h0001_0000};
    send_point(p);
    drain();
    write_reg(RegScreenWidth, 64'd0);
    write_reg(RegScreenHeight, 64'h3fff);
    p = '{32'h0, 32'h0, 32'h0001_0000};
    send_point(p);
    drain();
  endtask

  task automatic test_random_phases();
    point_t p;
    for (int ph = 0; ph < 8; ph++) begin
      for (int r = 0; r < MatRegs; r++) write_reg(r[CfgIdxWidth-1:0], {$urandom(), $urandom()});
      if (ph % 2 == 0) load_camera(rand_q(), 32'($urandom_range(0, 3 << 16)), 32'($urandom_range(0, 8)));
      write_reg(RegScreenWidth, 64'($urandom_range(1, 8192)));
      write_reg(RegScreenHeight, 64'(ph == 7 ? 8192 : $urandom_range(1, 8192)));
      if (ph == 7) gaps_on = 1'b0;
      for (int i = 0; i < 160; i++) begin
        p = rand_point();
        if (ph % 2 == 0 && $urandom_range(0, 3) != 0) p.pos_z = 32'($urandom_range(1, 30 << 16));
        send_point(p);
      end
      drain();
    end
  endtask

  initial begin
    foreach (mat_q[i]) mat_q[i] = '0;
    width_q = WidthReset;
    height_q = HeightReset;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_values();
    test_directed();
    test_random_phases();
    if (mismatches == 0 && projected_q.size() == 0) begin
      $display("PASS perspective_projection");
    end else begin
      $display("FAIL perspective_projection");
    end
    $finish;
  end

endmodule
